FILE: sv/qsrl_pkg.sv
// shared types, codes and defaults for the query source rate limiter
package qsrl_pkg;

   localparam int DEFAULT_FIFO_DEPTH = 64;

   localparam int SRC_W    = 32;
   localparam int TIME_W   = 32;
   localparam int TICK_W   = 32;
   localparam int IGNORE_W = 20;
   localparam int VERD_W   = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [IGNORE_W-1:0] IGNORE_TICKS_RESET = IGNORE_W'(350);

   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_TICKS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ENFORCE_BANS = CSR_IDX_W'(1);

   localparam logic [VERD_W-1:0] VERDICT_IGNORED  = 2'd0;
   localparam logic [VERD_W-1:0] VERDICT_BANNED   = 2'd1;
   localparam logic [VERD_W-1:0] VERDICT_ACCEPTED = 2'd2;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_POP
   } state_type;

   // commands broadcast from control to every cell
   typedef struct packed {
      logic shift;
      logic pop_en;
   } chain_ctrl_type;

   // reduced status from the row of cells
   typedef struct packed {
      logic hit;
      logic pop_any;
      logic full;
   } chain_stat_type;

endpackage

FILE: sv/qsrl_cell.sv
// one entry of the source list: address, expiry tick and occupancy
module qsrl_cell
   import qsrl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  chain_ctrl_type    ctrl,
   input  logic [SRC_W-1:0]  prev_source,
   input  logic [TICK_W-1:0] prev_expiry,
   input  logic              prev_valid,
   input  logic              next_valid,
   input  logic [SRC_W-1:0]  key,
   input  logic [TICK_W-1:0] tick_count,
   output logic              valid,
   output logic [SRC_W-1:0]  source,
   output logic [TICK_W-1:0] expiry,
   output logic              match,
   output logic              pop
);

   logic              valid_ff, valid_in;
   logic [SRC_W-1:0]  source_ff;
   logic [TICK_W-1:0] expiry_ff;
   logic [TICK_W-1:0] diff;
   logic              oldest;

   always_comb begin
      diff   = tick_count - expiry_ff;
      // the last occupied cell holds the oldest entry
      oldest = valid_ff & ~next_valid;
      pop    = ctrl.pop_en & oldest & ~diff[TICK_W-1];
      match  = valid_ff & (source_ff == key);
      if (ctrl.shift) begin
         valid_in = prev_valid;
      end else if (pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         source_ff <= prev_source;
         expiry_ff <= prev_expiry;
      end
   end

   assign valid  = valid_ff;
   assign source = source_ff;
   assign expiry = expiry_ff;

endmodule

FILE: sv/qsrl_chain.sv
// row of entry cells, newest at cell zero, with hit, pop and full reduction
module qsrl_chain
   import qsrl_pkg::*;
#(
   parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   input  chain_ctrl_type    ctrl,
   input  logic [SRC_W-1:0]  new_source,
   input  logic [TICK_W-1:0] new_expiry,
   input  logic [SRC_W-1:0]  key,
   input  logic [TICK_W-1:0] tick_count,
   output chain_stat_type    stat
);

   logic [FIFO_DEPTH-1:0] valid_vec;
   logic [FIFO_DEPTH-1:0] match_vec;
   logic [FIFO_DEPTH-1:0] pop_vec;
   logic [SRC_W-1:0]      source_arr [FIFO_DEPTH];
   logic [TICK_W-1:0]     expiry_arr [FIFO_DEPTH];

   for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
      logic [SRC_W-1:0]  p_source;
      logic [TICK_W-1:0] p_expiry;
      logic              p_valid;
      logic              n_valid;

      if (i == 0) begin : g_first
         assign p_source = new_source;
         assign p_expiry = new_expiry;
         assign p_valid  = 1'b1;
      end else begin : g_rest
         assign p_source = source_arr[i-1];
         assign p_expiry = expiry_arr[i-1];
         assign p_valid  = valid_vec[i-1];
      end

      if (i == FIFO_DEPTH-1) begin : g_last
         assign n_valid = 1'b0;
      end else begin : g_mid
         assign n_valid = valid_vec[i+1];
      end

      qsrl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .prev_source (p_source),
         .prev_expiry (p_expiry),
         .prev_valid  (p_valid),
         .next_valid  (n_valid),
         .key         (key),
         .tick_count  (tick_count),
         .valid       (valid_vec[i]),
         .source      (source_arr[i]),
         .expiry      (expiry_arr[i]),
         .match       (match_vec[i]),
         .pop         (pop_vec[i])
      );
   end

   assign stat.hit     = |match_vec;
   assign stat.pop_any = |pop_vec;
   assign stat.full    = valid_vec[FIFO_DEPTH-1];

endmodule

FILE: sv/query_source_rate_limiter_top.sv
// query source rate limiter: control, configuration registers and result register
// query: accepted with the search over all cells in the same cycle, decided the next;
//   the result strobe is registered from the decide state; busy holds off a new item until then
// tick: busy for the pop sweep, which ends when no expired entry is left,
//   popping a single entry at the oldest cell each cycle
// reset: synchronous; empties the list, clears the tick counter, restores defaults
// results are strobed for one cycle; the receiver cannot stall
module query_source_rate_limiter_top
   import qsrl_pkg::*;
#(
   parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  logic [SRC_W-1:0]      req_source_ip,
   input  logic [TIME_W-1:0]     req_request_time,
   input  logic                  req_is_banned,
   output logic                  rsp_strobe,
   output logic [VERD_W-1:0]     rsp_verdict,
   output logic [TIME_W-1:0]     rsp_echo_time,
   output logic                  rsp_evicted,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   state_type state_ff, state_in;

   logic [IGNORE_W-1:0] ignore_ticks_ff;
   logic                enforce_bans_ff;
   logic [TICK_W-1:0]   tick_count_ff, tick_count_in;
   logic [SRC_W-1:0]    source_ff;
   logic [TIME_W-1:0]   time_ff;
   logic                banned_ff;
   logic                hit_ff;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [VERD_W-1:0]   rsp_verdict_ff, rsp_verdict_in;
   logic                rsp_evicted_ff, rsp_evicted_in;
   logic [TIME_W-1:0]   rsp_time_ff;

   logic                take;
   logic                decide_load;
   logic [TICK_W-1:0]   new_expiry;
   chain_ctrl_type      ctrl;
   chain_stat_type      stat;

   assign busy      = (state_ff != ST_IDLE);
   assign take      = start & ~busy;
   assign csr_ready = 1'b1;
   assign new_expiry = tick_count_ff + TICK_W'(ignore_ticks_ff);

   qsrl_chain #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .new_source (source_ff),
      .new_expiry (new_expiry),
      .key        (req_source_ip),
      .tick_count (tick_count_ff),
      .stat       (stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      tick_count_in  = tick_count_ff;
      ctrl.shift     = 1'b0;
      ctrl.pop_en    = 1'b0;
      decide_load    = 1'b0;
      rsp_strobe_in  = 1'b0;
      rsp_verdict_in = VERDICT_ACCEPTED;
      rsp_evicted_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_op == OP_QUERY) begin
                  decide_load = 1'b1;
                  state_in    = ST_DECIDE;
               end else begin
                  tick_count_in = tick_count_ff + TICK_W'(1);
                  state_in      = ST_POP;
               end
            end
         end
         ST_DECIDE: begin
            rsp_strobe_in = 1'b1;
            priority if (hit_ff) begin
               rsp_verdict_in = VERDICT_IGNORED;
            end else if (enforce_bans_ff && banned_ff) begin
               rsp_verdict_in = VERDICT_BANNED;
            end else begin
               rsp_verdict_in = VERDICT_ACCEPTED;
               // shifting a full row drops the oldest entry off the end
               rsp_evicted_in = stat.full;
               ctrl.shift     = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_POP: begin
            ctrl.pop_en = 1'b1;
            if (!stat.pop_any) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff   <= '0;
         ignore_ticks_ff <= IGNORE_TICKS_RESET;
         enforce_bans_ff <= 1'b1;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         tick_count_ff <= tick_count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IGNORE_TICKS) begin
               ignore_ticks_ff <= csr_data[IGNORE_W-1:0];
            end else if (csr_index == CSR_ENFORCE_BANS) begin
               enforce_bans_ff <= csr_data[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (decide_load) begin
         source_ff <= req_source_ip;
         time_ff   <= req_request_time;
         banned_ff <= req_is_banned;
         hit_ff    <= stat.hit;
      end
      if (rsp_strobe_in) begin
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_evicted_ff <= rsp_evicted_in;
         rsp_time_ff    <= time_ff;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_verdict   = rsp_verdict_ff;
   assign rsp_echo_time = rsp_time_ff;
   assign rsp_evicted   = rsp_evicted_ff;

`ifndef SYNTH
   a_strobe_after_decide: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DECIDE))
      else $error("result strobe without a decide cycle");

   a_evict_only_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_evicted |-> rsp_verdict == VERDICT_ACCEPTED)
      else $error("eviction flagged on a verdict other than accepted");

   a_full_shift_evicts: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift && stat.full |=> rsp_strobe && rsp_evicted)
      else $error("append to a full list not flagged as eviction");

   a_no_shift_while_pop: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop_en |-> !ctrl.shift && !rsp_strobe_in)
      else $error("append or result during the pop sweep");
`endif

endmodule
